>>> rtl/cid_pkg.sv
// Shared types and the elaboration-time binomial helper for the combinatorial
// index decoder. No dependencies.
package cid_pkg;

  localparam int unsigned WordWidth = 64;

  typedef logic [WordWidth-1:0] word_t;

  // Result hand-over from a cell to the output register
  typedef struct packed {
    logic emit;
    logic last;
    logic invalid;
  } cid_emit_t;

  // C(a,b) by Pascal rows, saturating at all ones; elaboration only
  function automatic word_t binom_const(input int a, input int b);
    logic [WordWidth:0] s;
    word_t row [0:16];
    for (int c = 0; c <= 16; c++) row[c] = '0;
    row[0] = word_t'(1);
    for (int r = 1; r <= a; r++) begin
      for (int c = 16; c >= 1; c--) begin
        s = {1'b0, row[c]} + {1'b0, row[c-1]};
        row[c] = s[WordWidth] ? '1 : s[WordWidth-1:0];
      end
    end
    return row[b];
  endfunction

endpackage

>>> rtl/combinatorial_index_decoder.sv
// Each request gives k results; an element is found by a binary search in its cell and then
// handed over to the output register; a cell holds its element while the output is stalled.
// Requests are taken one at a time, the next in the cycle after the last element leaves the cells,
// so output stalls also hold off the next request.
// Bad sizes give one result, flagged last and invalid, in the cycle after the request is taken.
// Reset: set_size 100, subset_size 4, all cells idle, output empty.
module combinatorial_index_decoder #(
  parameter int MAX_SET_SIZE    = 128,
  parameter int MAX_SUBSET_SIZE = 8,
  parameter int INDEX_WIDTH     = 41
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_index_i,
  input  logic [7:0]                       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [INDEX_WIDTH-1:0]           comb_index_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [$clog2(MAX_SET_SIZE)-1:0]  element_o,
  output logic                             last_o,
  output logic                             invalid_o
);
  import cid_pkg::*;

  localparam int MW = $clog2(MAX_SET_SIZE+1);
  localparam int EW = $clog2(MAX_SET_SIZE);
  localparam int NC = MAX_SUBSET_SIZE;

  localparam logic CfgSetSize    = 1'b0;
  localparam logic CfgSubsetSize = 1'b1;

  logic [7:0] set_size_q;
  logic [3:0] subset_size_q;

  logic bad, in_acc, load, out_free;
  logic out_valid_q, last_q, invalid_q;
  logic [EW-1:0] element_q;

  cid_emit_t              c_emit [1:NC];
  logic [EW-1:0]          c_elem [1:NC];
  logic [INDEX_WIDTH-1:0] c_rem  [1:NC];
  logic [MW-1:0]          c_lo   [1:NC];
  logic [NC:1]            c_busy;

  logic          any_emit, sel_last, sel_invalid;
  logic [EW-1:0] sel_elem;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q    <= 8'd100;
      subset_size_q <= 4'd4;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgSetSize:    set_size_q    <= cfg_data_i;
        CfgSubsetSize: subset_size_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign bad = (subset_size_q == 4'd0)
            || ({1'b0, subset_size_q} > 5'(MAX_SUBSET_SIZE))
            || ({1'b0, set_size_q} > 9'(MAX_SET_SIZE))
            || ({4'd0, subset_size_q} > set_size_q);

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (c_busy == '0) && (!bad || out_free);
  assign in_acc     = in_valid_i && in_ready_o;
  assign load       = in_acc && !bad;

  for (genvar j = 1; j <= NC; j++) begin : g_cell
    logic                   start;
    logic [INDEX_WIDTH-1:0] rem_in;
    logic [MW-1:0]          lo_in;
    if (j == NC) begin : g_top
      assign start  = load && (subset_size_q == 4'(j));
      assign rem_in = comb_index_i;
      assign lo_in  = '0;
    end else begin : g_mid
      assign start  = (load && (subset_size_q == 4'(j))) || c_emit[j+1].emit;
      assign rem_in = load ? comb_index_i : c_rem[j+1];
      assign lo_in  = load ? '0 : c_lo[j+1];
    end

    cid_cell #(
      .MAX_SET_SIZE(MAX_SET_SIZE),
      .INDEX_WIDTH (INDEX_WIDTH),
      .COL         (j)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .n_i       (MW'(set_size_q)),
      .start_i   (start),
      .rem_i     (rem_in),
      .lo_i      (lo_in),
      .out_free_i(out_free),
      .emit_o    (c_emit[j]),
      .elem_o    (c_elem[j]),
      .rem_o     (c_rem[j]),
      .lo_o      (c_lo[j]),
      .busy_o    (c_busy[j])
    );
  end

  // at most one cell is busy, so an OR picks the emitting one
  always_comb begin
    any_emit    = 1'b0;
    sel_last    = 1'b0;
    sel_invalid = 1'b0;
    sel_elem    = '0;
    for (int j = 1; j <= NC; j++) begin
      if (c_emit[j].emit) begin
        any_emit    = 1'b1;
        sel_last    = sel_last | c_emit[j].last;
        sel_invalid = sel_invalid | c_emit[j].invalid;
        sel_elem    = sel_elem | c_elem[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (any_emit || (in_acc && bad)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && bad) begin
      element_q <= '0;
      last_q    <= 1'b1;
      invalid_q <= 1'b1;
    end else if (any_emit) begin
      element_q <= sel_elem;
      last_q    <= sel_last;
      invalid_q <= sel_invalid;
    end
  end

  assign out_valid_o = out_valid_q;
  assign element_o   = element_q;
  assign last_o      = last_q;
  assign invalid_o   = invalid_q;

endmodule

>>> rtl/cid_cell.sv
// One decoder cell: binary search for the element whose binomial term is C(.,COL).
// Depends on cid_pkg.
module cid_cell #(
  parameter int MAX_SET_SIZE = 128,
  parameter int INDEX_WIDTH  = 41,
  parameter int COL          = 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [$clog2(MAX_SET_SIZE+1)-1:0]     n_i,
  input  logic                                  start_i,
  input  logic [INDEX_WIDTH-1:0]                rem_i,
  input  logic [$clog2(MAX_SET_SIZE+1)-1:0]     lo_i,
  input  logic                                  out_free_i,
  output cid_pkg::cid_emit_t                    emit_o,
  output logic [$clog2(MAX_SET_SIZE)-1:0]       elem_o,
  output logic [INDEX_WIDTH-1:0]                rem_o,
  output logic [$clog2(MAX_SET_SIZE+1)-1:0]     lo_o,
  output logic                                  busy_o
);
  import cid_pkg::*;

  localparam int MW = $clog2(MAX_SET_SIZE+1);
  localparam int AW = $clog2(MAX_SET_SIZE);

  word_t col [MAX_SET_SIZE];

  for (genvar a = 0; a < MAX_SET_SIZE; a++) begin : g_col
    assign col[a] = binom_const(a, COL);
  end

  logic                   busy_q, busy_d;
  logic [INDEX_WIDTH-1:0] rem_q, rem_d;
  logic [MW-1:0]          lo_q, lo_d, hi_q, hi_d;
  logic [MW:0]            mid_sum;
  logic [MW-1:0]          mid, sel;
  logic [MW:0]            a_full;
  word_t                  term;
  logic                   done, exceeds, emit;
  logic [INDEX_WIDTH-1:0] rem_new;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (MW+1)'(1);
  assign mid     = mid_sum[MW:1];
  assign done    = (lo_q >= hi_q);
  assign sel     = done ? hi_q : mid;
  // row index n - m - 1 stays within the table for every probed m
  assign a_full  = {1'b0, n_i} - {1'b0, sel} - (MW+1)'(1);
  assign term    = col[a_full[AW-1:0]];
  assign exceeds = (term == '1) || (term > word_t'(rem_q));
  assign rem_new = rem_q - term[INDEX_WIDTH-1:0];
  assign emit    = busy_q && done && out_free_i;

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    if (start_i) begin
      busy_d = 1'b1;
      rem_d  = rem_i;
      lo_d   = lo_i;
      hi_d   = n_i - MW'(COL);
    end else if (busy_q && !done) begin
      if (exceeds) begin
        lo_d = mid + MW'(1);
      end else begin
        hi_d = mid;
      end
    end else if (emit) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
  end

  assign emit_o.emit    = emit;
  assign emit_o.last    = (COL == 1);
  assign emit_o.invalid = (COL == 1) && (rem_new != '0);
  assign elem_o         = hi_q[AW-1:0];
  assign rem_o          = rem_new;
  assign lo_o           = hi_q + MW'(1);
  assign busy_o         = busy_q;

endmodule

>>> rtl/cid_checker.sv
// Port-level checks for the combinatorial index decoder, bound to the top level.
// No package dependencies.
module cid_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic last_o,
  input logic invalid_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_invalid_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_o |-> last_o)
    else $error("invalid flag on a non-final element");

  // a non-final element on the output means the next cell is still busy
  a_busy_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input ready while a subset is in progress");

endmodule

bind combinatorial_index_decoder cid_checker u_cid_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .last_o     (last_o),
  .invalid_o  (invalid_o)
);

>>> tb/sv/combinatorial_index_decoder_test.sv
// Self-checking testbench for combinatorial_index_decoder: random and directed
// index requests under several set/subset sizes, checked against a local decoder.
// Depends on the RTL top level only.
module combinatorial_index_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CfgSetSize    = 0;
  localparam int CfgSubsetSize = 1;
  localparam int MaxSet        = 128;
  localparam int MaxSubset     = 8;
  localparam int IdxW          = 41;
  localparam longint unsigned Limit = 400000;
  localparam logic [63:0] IdxMax = (64'd1 << IdxW) - 64'd1;

  typedef struct packed {
    logic [6:0] element;
    logic       last;
    logic       invalid;
  } subset_elem_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic            cfg_index_i = 1'b0;
  logic [7:0]      cfg_data_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [IdxW-1:0] comb_index_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [6:0]      element_o;
  logic            last_o;
  logic            invalid_o;

  combinatorial_index_decoder dut (.*);

  always #4 clk_i = ~clk_i;

  logic [63:0]          pascal [MaxSet][MaxSubset+1];
  logic [IdxW-1:0]      pending_idx [$];
  subset_elem_t         expected_elems [$];
  int                   n_set = 100;
  int                   k_sub = 4;
  int                   errors = 0;
  int                   send_idle_pct = 7;
  int                   recv_idle_pct = 51;
  longint unsigned      cycles = 0;

  function automatic logic [63:0] choose(int a, int b);
    if (a < 0 || b < 0 || a >= MaxSet || b > MaxSubset || a < b) return '0;
    return pascal[a][b];
  endfunction

  // Decode one index into its ascending subset and queue the elements
  function automatic void decode_subset(logic [IdxW-1:0] idx);
    logic [63:0] rem;
    logic [63:0] t;
    int lo;
    int hi;
    int mid;
    rem = 64'(idx);
    lo = -1;
    if (k_sub == 0 || k_sub > MaxSubset || n_set > MaxSet || k_sub > n_set) begin
      expected_elems.push_back('{7'd0, 1'b1, 1'b1});
      return;
    end
    for (int i = 0; i < k_sub; i++) begin
      hi = n_set - k_sub + i;
      while (lo < hi - 1) begin
        mid = (lo + hi) / 2;
        t = choose(n_set - mid - 1, k_sub - i);
        if (t == '1 || t > rem) lo = mid;
        else hi = mid;
      end
      rem -= choose(n_set - hi - 1, k_sub - i);
      lo++;
      expected_elems.push_back('{7'(hi), i == k_sub - 1,
                                 (i == k_sub - 1) && (rem != 0)});
    end
  endfunction

  task automatic report(string what, logic [8:0] got, logic [8:0] exp);
    $display("mismatch %s: got %h expected %h", what, got, exp);
    errors++;
  endtask

  // Driver: feeds requests from the pending queue
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      decode_subset(comb_index_i);
      if (pending_idx.size() > 0 && $urandom_range(99) >= send_idle_pct)
        comb_index_i <= pending_idx.pop_front();
      else
        in_valid_i <= 1'b0;
    end else if (!in_valid_i && rst_ni && pending_idx.size() > 0 &&
                 $urandom_range(99) >= send_idle_pct) begin
      comb_index_i <= pending_idx.pop_front();
      in_valid_i   <= 1'b1;
    end
  end

  // Monitor: compares each result with the oldest expectation
  always @(posedge clk_i) begin
    subset_elem_t e;
    cycles++;
    if (out_valid_o && out_ready_i) begin
      if (expected_elems.size() == 0) begin
        report("unexpected result", {element_o, last_o, invalid_o}, '0);
      end else begin
        e = expected_elems.pop_front();
        if (element_o !== e.element) report("element", 9'(element_o), 9'(e.element));
        if (last_o !== e.last) report("last", 9'(last_o), 9'(e.last));
        if (invalid_o !== e.invalid) report("invalid", 9'(invalid_o), 9'(e.invalid));
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    if (cycles > Limit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_idx.size() > 0 || in_valid_i || expected_elems.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(int idx, int val);
    cfg_index_i <= 1'(idx);
    cfg_data_i  <= 8'(val);
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CfgSetSize) n_set = val;
    else k_sub = val & 4'hf;
    @(posedge clk_i);
  endtask

  // C(n,k) through Pascal's rule so that n = MaxSet is covered
  function automatic logic [63:0] subset_count(int n, int k);
    if (n < 1 || k < 1) return '0;
    return choose(n - 1, k) + choose(n - 1, k - 1);
  endfunction

  function automatic logic [IdxW-1:0] rand_index(int mode);
    logic [63:0] span;
    span = subset_count(n_set, k_sub);
    if (mode == 0 || span == 0) return IdxW'({$urandom, $urandom});
    if (span > IdxMax) span = IdxMax;
    return IdxW'({$urandom, $urandom} % span);
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++)
      pending_idx.push_back(rand_index($urandom_range(9) != 0));
    wait_drained();
  endtask

  initial begin
    int setting [10][2];
    setting = '{'{100, 4}, '{128, 8}, '{1, 1}, '{8, 8}, '{128, 1},
                '{37, 5}, '{3, 8}, '{0, 2}, '{200, 3}, '{20, 0}};
    for (int a = 0; a < MaxSet; a++) begin
      pascal[a][0] = 1;
      for (int b = 1; b <= MaxSubset; b++)
        pascal[a][b] = (a == 0) ? '0 : pascal[a-1][b-1] + pascal[a-1][b];
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes and too-large index at reset sizes and largest sizes, then bad sizes
    pending_idx = '{'0, 41'd1, 41'd3921224, 41'd3921225, '1, 41'h15555555555};
    wait_drained();
    write_reg(CfgSetSize, 128);
    write_reg(CfgSubsetSize, 8);
    pending_idx = '{'0, 41'(subset_count(128, 8) - 64'd1), '1, 41'h0aaaaaaaaaa, 41'd12345};
    wait_drained();
    write_reg(CfgSubsetSize, 15);
    pending_idx = '{41'd5};
    wait_drained();
    write_reg(CfgSetSize, 255);
    write_reg(CfgSubsetSize, 2);
    pending_idx = '{41'd7};
    wait_drained();
    for (int p = 0; p < 3; p++) begin
      if (p == 1) begin send_idle_pct = 51; recv_idle_pct = 7; end
      if (p == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int s = 0; s < 10; s++) begin
        write_reg(CfgSetSize, setting[s][0]);
        write_reg(CfgSubsetSize, setting[s][1]);
        random_phase(s < 7 ? 14 : 3);
      end
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/cid_pkg.sv
rtl/cid_cell.sv
rtl/combinatorial_index_decoder.sv
rtl/cid_checker.sv
tb/sv/combinatorial_index_decoder_test.sv
